// File: rtl/core/fae_pkg.sv
// ----------------------------------------------------------------------------
// fae_pkg
// Shared types and constants for the fade alpha envelope block.
// ----------------------------------------------------------------------------
package fae_pkg;

  localparam int FADE_W  = 16;
  localparam int TIME_W  = 32;
  localparam int ALPHA_W = 8;
  // numerator of the scaling divide: 255 * n with n below 2^FADE_W
  localparam int NUM_W   = FADE_W + ALPHA_W;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'd0;

  typedef enum logic [IDX_W-1:0] {
    CFG_FADE_TIME  = 2'd0,
    CFG_TOTAL_TIME = 2'd1,
    CFG_LOOP_MODE  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CANCEL = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_SEL,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] now;
    logic              playing;
  } in_item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               stop_request;
    logic               cancel_taken;
  } out_item_t;

endpackage

// File: rtl/core/fade_alpha_envelope.sv
// ----------------------------------------------------------------------------
// fade_alpha_envelope
// Opacity envelope for a clip: fade-in, fade-out near the end and fade-out
// after a recorded cancel, with a cancel that may request an immediate stop.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_ready, in_data          | to block
//  out     | out_valid, out_ready, out_data       | from block
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | to block
//
//  An item passes the command and select states, then the 8-step shared
//  divider when alpha needs the scaling divide, and then the hold state.
//  in_ready is high only while no item is in work; one result register sits
//  on the output, so the next item is taken while a result waits.
//  Synchronous reset clears state, config registers, out_valid and the cancel stamp.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module fade_alpha_envelope (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fae_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fae_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fae_pkg::IDX_W-1:0]  cfg_index,
  input  logic [fae_pkg::CFG_W-1:0]  cfg_data
);
  import fae_pkg::*;

  state_t              state, state_next;
  logic [FADE_W-1:0]   fade_time;
  logic [TIME_W-1:0]   total_time;
  logic                loop_mode;
  logic [TIME_W-1:0]   cancel_stamp;

  logic                op_r;
  logic                playing_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W:0]     diff;
  logic                stop_r;
  logic                taken_r;
  logic [ALPHA_W-1:0]  alpha_r;

  logic [TIME_W:0]     diff_c;
  logic                near_end;
  logic                do_stop;
  logic                do_take;

  logic                past_end;
  logic [TIME_W-1:0]   since_cancel;
  logic                use_div;
  logic [FADE_W-1:0]   sel_n;
  logic [ALPHA_W-1:0]  sel_alpha;
  logic [NUM_W-1:0]    div_num;
  logic                div_start;
  logic                div_done;
  logic [ALPHA_W-1:0]  div_quo;
  logic                hold_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_time  <= '0;
      total_time <= '0;
      loop_mode  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FADE_TIME:  fade_time  <= cfg_data[FADE_W-1:0];
        CFG_TOTAL_TIME: total_time <= cfg_data[TIME_W-1:0];
        CFG_LOOP_MODE:  loop_mode  <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // cancel decision, time left to the end
  always_comb begin
    diff_c   = {1'b0, total_time} - {1'b0, now_r};
    near_end = !diff_c[TIME_W] && (diff_c[TIME_W-1:0] <= {{(TIME_W-FADE_W){1'b0}}, fade_time});
    do_stop  = 1'b0;
    do_take  = 1'b0;
    if (op_r == OP_CANCEL && playing_r) begin
      if (loop_mode || fade_time == '0) begin
        do_stop = 1'b1;
      end else if (cancel_stamp == '0 &&
                   now_r > {{(TIME_W-FADE_W){1'b0}}, fade_time} && !near_end) begin
        do_take = 1'b1;
      end
    end
  end

  // alpha selection, with the divide numerator where one is needed
  always_comb begin
    past_end     = diff[TIME_W] || (diff[TIME_W-1:0] == '0);
    since_cancel = now_r - cancel_stamp;
    use_div      = 1'b0;
    sel_n        = '0;
    sel_alpha    = ALPHA_OPAQUE;
    if (fade_time == '0) begin
      sel_alpha = ALPHA_OPAQUE;
    end else if (past_end) begin
      sel_alpha = ALPHA_CLEAR;
    end else if (now_r < {{(TIME_W-FADE_W){1'b0}}, fade_time}) begin
      use_div = 1'b1;
      sel_n   = now_r[FADE_W-1:0];
    end else if (cancel_stamp != '0 && now_r > cancel_stamp) begin
      if (since_cancel <= {{(TIME_W-FADE_W){1'b0}}, fade_time}) begin
        use_div = 1'b1;
        sel_n   = fade_time - since_cancel[FADE_W-1:0];
      end else begin
        sel_alpha = ALPHA_CLEAR;
      end
    end else if (diff[TIME_W-1:0] < {{(TIME_W-FADE_W){1'b0}}, fade_time}) begin
      use_div = 1'b1;
      sel_n   = diff[FADE_W-1:0];
    end
    // 255 * n as n * 256 - n
    div_num = {sel_n, {ALPHA_W{1'b0}}} - {{ALPHA_W{1'b0}}, sel_n};
  end

  assign hold_load = (state == ST_HOLD) && (!out_valid || out_ready);

  // sequencer: next state and divider start
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CMD;
      end
      ST_CMD: begin
        state_next = ST_SEL;
      end
      ST_SEL: begin
        if (use_div) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_DIV: begin
        if (div_done) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (hold_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // cancel stamp, written only by a recorded cancel
  always_ff @(posedge clk) begin
    if (rst) begin
      cancel_stamp <= '0;
    end else if (state == ST_CMD && do_take) begin
      cancel_stamp <= now_r;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_r      <= in_data.op;
      now_r     <= in_data.now;
      playing_r <= in_data.playing;
    end
    if (state == ST_CMD) begin
      diff    <= diff_c;
      stop_r  <= do_stop;
      taken_r <= do_take;
    end
    if (state == ST_SEL) begin
      alpha_r <= sel_alpha;
    end else if (state == ST_DIV && div_done) begin
      alpha_r <= div_quo;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hold_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      out_data.alpha        <= alpha_r;
      out_data.stop_request <= stop_r;
      out_data.cancel_taken <= taken_r;
    end
  end

  fae_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (fade_time),
    .done  (div_done),
    .quo   (div_quo)
  );

  stamp_only_on_cancel: assert property (@(posedge clk) disable iff (rst)
    !$stable(cancel_stamp) |-> $past(state) == ST_CMD && $past(do_take))
    else $error("cancel stamp changed outside a recorded cancel");

  stamp_never_zero: assert property (@(posedge clk) disable iff (rst)
    $past(state) == ST_CMD && $past(do_take) |-> cancel_stamp != '0)
    else $error("recorded cancel left a zero stamp");

  stop_excludes_take: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.stop_request && out_data.cancel_taken))
    else $error("stop request and recorded cancel in one result");

  div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

endmodule

// File: rtl/core/fae_div.sv
// ----------------------------------------------------------------------------
// fae_div
// Restoring divider, one quotient bit per cycle; quotient fits in 8 bits
// because the numerator is at most 255 times the divisor.
// ----------------------------------------------------------------------------
module fae_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fae_pkg::NUM_W-1:0]    num,
  input  logic [fae_pkg::FADE_W-1:0]   den,
  output logic                         done,
  output logic [fae_pkg::ALPHA_W-1:0]  quo
);
  import fae_pkg::*;

  localparam int CNT_W = $clog2(ALPHA_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsr;
  logic [NUM_W:0]    trial;

  // trial subtract of the shifted divisor
  assign trial = {1'b0, rem} - {1'b0, dsr};

  // control: busy, step count and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ALPHA_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder, divisor and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsr <= {den, {(ALPHA_W - 1){1'b0}}, 1'b0} >> 1;
      quo <= '0;
    end else if (busy) begin
      if (!trial[NUM_W]) begin
        rem <= trial[NUM_W-1:0];
        quo <= {quo[ALPHA_W-2:0], 1'b1};
      end else begin
        quo <= {quo[ALPHA_W-2:0], 1'b0};
      end
      dsr <= dsr >> 1;
    end
  end

  done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a finished run");

  no_restart_busy: assert property (@(posedge clk) disable iff (rst)
    busy && !start |=> (busy || done))
    else $error("divider run ended without done");

  quo_bounded_cnt: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && cnt == CNT_W'(ALPHA_W - 1))
    else $error("divider did not load its step count");

endmodule

// File: bench/fae_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fae_check
// Watches the config, input and output channels of the fade alpha envelope,
// keeps its own copy of the registers and the cancel stamp, predicts one
// result per accepted input transaction and compares results in order.
// ----------------------------------------------------------------------------
module fae_check (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  fae_pkg::in_item_t          in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  fae_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [fae_pkg::IDX_W-1:0]  cfg_index,
  input  logic [fae_pkg::CFG_W-1:0]  cfg_data,
  output int                         fail_count,
  output int                         pending,
  output int                         checked
);
  import fae_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // shadow registers and the recorded cancel time
  logic [FADE_W-1:0] fade_q;
  logic [TIME_W-1:0] total_q;
  logic              loop_q;
  logic [TIME_W-1:0] stamp_q;

  out_item_t envelope_q[$];
  out_item_t want;
  int        mismatches;
  int        results_seen;

  // 255 * span / fade, rounded down
  function automatic logic [ALPHA_W-1:0] ramp(logic [TIME_W-1:0] span);
    logic [63:0] prod;
    prod = 64'(span) * 64'd255;
    return ALPHA_W'(prod / 64'(fade_q));
  endfunction

  // opacity for time t with the current registers and stamp
  function automatic logic [ALPHA_W-1:0] envelope_alpha(logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] fade_span;
    logic [TIME_W-1:0] since_cancel;
    fade_span = TIME_W'(fade_q);
    if (fade_q == '0) return ALPHA_OPAQUE;
    if (t >= total_q) return ALPHA_CLEAR;
    if (t < fade_span) return ramp(t);
    if (stamp_q != '0 && t > stamp_q) begin
      since_cancel = t - stamp_q;
      if (since_cancel <= fade_span) return ramp(fade_span - since_cancel);
      return ALPHA_CLEAR;
    end
    if (total_q - t < fade_span) return ramp(total_q - t);
    return ALPHA_OPAQUE;
  endfunction

  // act on the op first, then report alpha for the new time
  function automatic out_item_t predict_envelope(in_item_t it);
    out_item_t         res;
    logic              near_end;
    logic [TIME_W-1:0] fade_span;
    res = '0;
    fade_span = TIME_W'(fade_q);
    if (it.op == OP_CANCEL && it.playing) begin
      if (loop_q || fade_q == '0) begin
        res.stop_request = 1'b1;
      end else begin
        // past the end the near-end refusal does not apply
        near_end = (it.now <= total_q) && (total_q - it.now <= fade_span);
        if (stamp_q == '0 && it.now > fade_span && !near_end) begin
          stamp_q = it.now;
          res.cancel_taken = 1'b1;
        end
      end
    end
    res.alpha = envelope_alpha(it.now);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fade_q       = '0;
      total_q      = '0;
      loop_q       = 1'b0;
      stamp_q      = '0;
      mismatches   = 0;
      results_seen = 0;
      envelope_q.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FADE_TIME:  fade_q  = cfg_data[FADE_W-1:0];
          CFG_TOTAL_TIME: total_q = cfg_data[TIME_W-1:0];
          CFG_LOOP_MODE:  loop_q  = cfg_data[0];
          default: ;
        endcase
      end

      // result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        results_seen++;
        if (envelope_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result alpha %0d stop %0b taken %0b", $time,
                     out_data.alpha, out_data.stop_request, out_data.cancel_taken);
        end else begin
          want = envelope_q.pop_front();
          if (out_data.alpha !== want.alpha ||
              out_data.stop_request !== want.stop_request ||
              out_data.cancel_taken !== want.cancel_taken) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: mismatch: expected alpha %0d stop %0b taken %0b, got %0d %0b %0b",
                       $time, want.alpha, want.stop_request, want.cancel_taken,
                       out_data.alpha, out_data.stop_request, out_data.cancel_taken);
          end
        end
      end

      // input transaction
      if (in_valid && in_ready)
        envelope_q.push_back(predict_envelope(in_data));
    end
    fail_count <= mismatches;
    pending    <= envelope_q.size();
    checked    <= results_seen;
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the fade alpha envelope through directed edge cases and random
// register settings with random idling on both channels, including one long
// output hold-off; fae_check predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import fae_pkg::*;

  localparam int RESET_CYCLES    = 10;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int CALM_PHASES     = 2;
  localparam int SQUEEZE_PHASE   = 3;
  localparam int SQUEEZE_CYCLES  = 300;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 20;
  localparam logic [TIME_W-1:0] CANCEL_AT = 32'd2000;
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  int fail_count;
  int pending;
  int checked;

  // stimulus bookkeeping
  bit                idle_on;
  bit                squeeze_req;
  logic [FADE_W-1:0] cur_fade;
  logic [TIME_W-1:0] cur_total;
  logic [TIME_W-1:0] playhead;
  int                items_sent;
  int                settings_used;
  int                stall_cycles;

  fade_alpha_envelope dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fae_check u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // clock
  always #2 clk = ~clk;

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: random holds, one long hold-off on request
  initial begin
    do @(posedge clk); while (rst);
    forever begin
      if (squeeze_req) begin
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic in_item_t item_of(op_t op, logic [TIME_W-1:0] t, logic play);
    in_item_t it;
    it.op      = op;
    it.now     = t;
    it.playing = play;
    return it;
  endfunction

  // one input transaction, valid stays high afterwards
  task automatic push_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // one register write, valid stays high afterwards
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_settings(input logic [FADE_W-1:0] fade,
                                input logic [TIME_W-1:0] total, input logic loop);
    cur_fade  = fade;
    cur_total = total;
    write_reg(CFG_FADE_TIME, CFG_W'(fade));
    write_reg(CFG_TOTAL_TIME, CFG_W'(total));
    write_reg(CFG_LOOP_MODE, CFG_W'(loop));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // times clustered around fade-in, the end, the cancel point, the top of the range and a playhead, or random
  function automatic logic [TIME_W-1:0] pick_now();
    logic [TIME_W-1:0] reach;
    reach = TIME_W'(cur_fade) + 3;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, reach);
      1: return cur_total - $urandom_range(0, reach);
      2: return cur_total + $urandom_range(0, 3);
      3: return CANCEL_AT + $urandom_range(0, reach);
      4: return $urandom;
      5: return TIME_MAX - $urandom_range(0, 3);
      default: begin
        playhead = playhead + $urandom_range(0, reach / 16 + 1);
        return playhead;
      end
    endcase
  endfunction

  initial begin
    logic [FADE_W-1:0] fade;
    logic [TIME_W-1:0] total;
    logic              loop;
    op_t               op;

    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_FADE_TIME;
    cfg_data    = '0;
    idle_on     = 1'b1;
    squeeze_req = 1'b0;
    playhead    = '0;
    items_sent  = 0;
    settings_used = 0;
    stall_cycles  = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: ramp-in, plateau, near-end ramp, end, refused cancels and a recorded one
    write_settings(16'd100, 32'd1000, 1'b0);
    push_item(item_of(OP_UPDATE, 32'd0, 1'b1));
    push_item(item_of(OP_UPDATE, 32'd50, 1'b1));
    push_item(item_of(OP_UPDATE, 32'd99, 1'b1));
    push_item(item_of(OP_UPDATE, 32'd500, 1'b1));
    push_item(item_of(OP_UPDATE, 32'd950, 1'b1));
    push_item(item_of(OP_UPDATE, 32'd1000, 1'b1));
    push_item(item_of(OP_UPDATE, TIME_MAX, 1'b0));
    // cancel exactly at the fade time
    push_item(item_of(OP_CANCEL, 32'd100, 1'b1));
    // cancel while not playing
    push_item(item_of(OP_CANCEL, 32'd500, 1'b0));
    // cancel within one fade time of the end, and exactly at the end
    push_item(item_of(OP_CANCEL, 32'd900, 1'b1));
    push_item(item_of(OP_CANCEL, 32'd1000, 1'b1));
    // cancel past the end is recorded; a second one is refused
    push_item(item_of(OP_CANCEL, CANCEL_AT, 1'b1));
    push_item(item_of(OP_CANCEL, 32'd2500, 1'b1));
    drain_results();

    // fading disabled: cancel asks for a stop
    write_settings(16'd0, TIME_MAX, 1'b0);
    push_item(item_of(OP_CANCEL, 32'd5, 1'b1));
    push_item(item_of(OP_CANCEL, 32'd5, 1'b0));
    push_item(item_of(OP_UPDATE, TIME_MAX, 1'b1));
    drain_results();

    // loop mode with the widest fade
    write_settings(16'hFFFF, TIME_MAX, 1'b1);
    push_item(item_of(OP_CANCEL, 32'd70000, 1'b1));
    push_item(item_of(OP_UPDATE, 32'd65534, 1'b1));
    drain_results();

    // fade-out after the recorded cancel
    write_settings(16'd100, 32'd100000, 1'b0);
    push_item(item_of(OP_UPDATE, CANCEL_AT, 1'b1));
    push_item(item_of(OP_UPDATE, CANCEL_AT + 1, 1'b1));
    push_item(item_of(OP_UPDATE, CANCEL_AT + 100, 1'b1));
    push_item(item_of(OP_UPDATE, 32'd99950, 1'b1));
    push_item(item_of(OP_CANCEL, 32'd3000, 1'b1));
    drain_results();

    // random phases, each with its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          fade = 16'd1;
          total = '0;
          loop = 1'b0;
        end
        1: begin
          fade = 16'hFFFF;
          total = TIME_MAX;
          loop = 1'b0;
        end
        2: begin
          fade = '0;
          total = $urandom;
          loop = 1'b0;
        end
        default: begin
          fade = ($urandom_range(0, 3) == 0) ? FADE_W'($urandom_range(0, 65535))
                                              : FADE_W'($urandom_range(1, 400));
          total = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom)
                                               : CANCEL_AT + $urandom_range(0, 20000);
          loop = ($urandom_range(0, 4) == 0);
        end
      endcase
      if (p >= RANDOM_PHASES - CALM_PHASES)
        idle_on = 1'b0;
      write_settings(fade, total, loop);
      playhead = $urandom_range(0, 3000);
      if (p == SQUEEZE_PHASE)
        squeeze_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        op = ($urandom_range(0, 3) == 0) ? OP_CANCEL : OP_UPDATE;
        push_item(item_of(op, pick_now(), $urandom_range(0, 4) != 0));
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run: %0d items over %0d register settings, %0d results checked",
             items_sent, settings_used, checked);
    $display("run: ramp-in, near-end ramp, post-cancel fade, stops and refused cancels");
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
